FILE: sv/bha_pkg.sv
// Shared types, constants and helpers for the bitmap hole allocator.
`default_nettype none
package bha_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int WORD_BITS = 32;
  localparam int ROWS      = MEM_BYTES / WORD_BITS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = OFF_W + 1;
  localparam int ADDR_W    = 12;
  localparam int POS_W     = 13;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_COMPACT = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] REG_FIT_POLICY    = 2'd0;
  localparam logic [1:0] REG_RESERVED_SIZE = 2'd1;
  localparam logic [1:0] REG_MEM_SIZE      = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  length;
    logic [ADDR_W-1:0] start_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_base;
  } rsp_t;

  typedef struct packed {
    logic                 en;
    logic [ROW_W-1:0]     row;
    logic [WORD_BITS-1:0] data;
  } map_wr_t;

  // Low n bits set, n in 0..WORD_BITS.
  function automatic logic [WORD_BITS-1:0] thermo(input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bitmap_hole_allocator.sv
// Bitmap hole allocator top level: sequencer, run scanner and range writer.
// Allocate: accept, a scan step for each used or free stretch cut at row edges, an end check,
//   decide, a write over the rows covered by the grant, reply; free: accept, row writes, reply.
// One item at a time; a held reply blocks the next item; scan steps set the rate.
// Reset: map reads empty at once through row valid bits, no clearing pass;
//   fit_policy 0, reserved_size 128, mem_size 4096.
`default_nettype none
module bitmap_hole_allocator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire bha_pkg::req_t       req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output bha_pkg::rsp_t            rsp,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [bha_pkg::POS_W-1:0] cfg_data
);
  import bha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_WRITE  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state;

  logic [1:0]       fit_policy;
  logic [POS_W-1:0] reserved_size;
  logic [POS_W-1:0] mem_size;

  logic [POS_W-1:0]  len_q;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  run_len;
  logic [ADDR_W-1:0] run_base;
  logic [POS_W-1:0]  total;
  logic [ADDR_W-1:0] best_base;
  logic [POS_W-1:0]  best_size;
  logic              found;
  logic [POS_W-1:0]  wpos;
  logic [POS_W-1:0]  wend;
  logic              set_bits;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_base;

  map_wr_t              map_wr;
  logic [ROW_W-1:0]     rd_row;
  logic [WORD_BITS-1:0] map_word;

  bha_map u_map (
    .clk     (clk),
    .rst     (rst),
    .wr      (map_wr),
    .rd_row  (rd_row),
    .rd_word (map_word)
  );

  function automatic logic [CNT_W-1:0] cnt_below(input logic [POS_W-1:0] limit,
                                                 input logic [POS_W-1:0] row_lo,
                                                 input logic [POS_W:0]   row_hi);
    if ({1'b0, limit} >= row_hi) begin
      return CNT_W'(WORD_BITS);
    end else if (limit <= row_lo) begin
      return '0;
    end else begin
      return {1'b0, limit[OFF_W-1:0]};
    end
  endfunction

  function automatic logic [CNT_W-1:0] first_zero(input logic [WORD_BITS-1:0] v);
    logic [CNT_W-1:0] n;
    n = CNT_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        n = CNT_W'(i);
      end
    end
    return n;
  endfunction

  // scan step
  logic [POS_W-1:0]     lim;
  logic [POS_W-1:0]     row_lo;
  logic [POS_W:0]       row_hi;
  logic [WORD_BITS-1:0] used_word;
  logic [WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0] same;
  logic                 cur_used;
  logic [CNT_W-1:0]     seg;
  logic [POS_W-1:0]     pos_next;
  logic                 at_end;
  logic                 close_run;
  logic                 take;

  assign lim       = (mem_size > POS_W'(MEM_BYTES)) ? POS_W'(MEM_BYTES) : mem_size;
  assign row_lo    = {1'b0, pos[ADDR_W-1:OFF_W], OFF_W'(0)};
  assign row_hi    = {1'b0, row_lo} + (POS_W+1)'(WORD_BITS);
  assign used_word = map_word | thermo(cnt_below(reserved_size, row_lo, row_hi))
                   | ~thermo(cnt_below(lim, row_lo, row_hi));
  assign shifted   = used_word >> pos[OFF_W-1:0];
  assign cur_used  = shifted[0];
  assign same      = (cur_used ? shifted : ~shifted)
                   & thermo(CNT_W'(WORD_BITS) - {1'b0, pos[OFF_W-1:0]});
  assign seg       = first_zero(same);
  assign pos_next  = pos + POS_W'(seg);
  assign at_end    = (pos >= lim);
  assign close_run = (at_end || cur_used) && (run_len != '0);
  assign take      = (run_len >= len_q)
                   && (!found
                       || (fit_policy == POL_BEST && run_len < best_size)
                       || (fit_policy == POL_WORST && run_len > best_size));

  // range write step
  logic [ROW_W-1:0]     w_row;
  logic [CNT_W-1:0]     w_hi;
  logic [WORD_BITS-1:0] w_mask;
  logic [POS_W-1:0]     wpos_step;
  logic [POS_W:0]       free_sum;
  logic [POS_W-1:0]     free_end;

  assign w_row     = wpos[ADDR_W-1:OFF_W];
  assign w_hi      = (wend[POS_W-1:OFF_W] == {1'b0, w_row}) ? {1'b0, wend[OFF_W-1:0]}
                                                            : CNT_W'(WORD_BITS);
  assign w_mask    = thermo(w_hi) & ~thermo({1'b0, wpos[OFF_W-1:0]});
  assign wpos_step = {wpos[POS_W-1:OFF_W] + (POS_W-OFF_W)'(1), OFF_W'(0)};
  assign free_sum  = (POS_W+1)'(req.start_address) + (POS_W+1)'(req.length);
  assign free_end  = (free_sum > (POS_W+1)'(MEM_BYTES)) ? POS_W'(MEM_BYTES)
                                                        : free_sum[POS_W-1:0];

  assign map_wr.en   = (state == S_WRITE);
  assign map_wr.row  = w_row;
  assign map_wr.data = set_bits ? (map_word | w_mask) : (map_word & ~w_mask);

  always_comb begin
    unique case (state)
      S_IDLE:   rd_row = req.cmd ? req.start_address[ADDR_W-1:OFF_W] : '0;
      S_SCAN:   rd_row = pos_next[ADDR_W-1:OFF_W];
      S_DECIDE: rd_row = best_base[ADDR_W-1:OFF_W];
      S_WRITE:  rd_row = wpos_step[ADDR_W-1:OFF_W];
      default:  rd_row = '0;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= 2'd0;
      reserved_size <= POS_W'(128);
      mem_size      <= POS_W'(MEM_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIT_POLICY:    fit_policy    <= cfg_data[1:0];
        REG_RESERVED_SIZE: reserved_size <= cfg_data;
        REG_MEM_SIZE:      mem_size      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            len_q <= req.length;
            if (req.cmd) begin
              wpos       <= {1'b0, req.start_address};
              wend       <= free_end;
              set_bits   <= 1'b0;
              res_status <= ST_DONE;
              res_base   <= '0;
              state      <= (req.length == '0) ? S_RESP : S_WRITE;
            end else begin
              pos        <= '0;
              run_len    <= '0;
              total      <= '0;
              found      <= 1'b0;
              best_size  <= '0;
              best_base  <= '0;
              res_status <= ST_OOM;
              res_base   <= '0;
              state      <= (req.length == '0) ? S_RESP : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (close_run) begin
            total   <= total + run_len;
            run_len <= '0;
            if (take) begin
              found     <= 1'b1;
              best_base <= run_base;
              best_size <= run_len;
            end
          end else if (!at_end && !cur_used) begin
            if (run_len == '0) begin
              run_base <= pos[ADDR_W-1:0];
            end
            run_len <= run_len + POS_W'(seg);
          end
          if (at_end) begin
            state <= S_DECIDE;
          end else begin
            pos <= pos_next;
          end
        end
        S_DECIDE: begin
          if (found) begin
            wpos       <= {1'b0, best_base};
            wend       <= POS_W'({1'b0, best_base} + len_q);
            set_bits   <= 1'b1;
            res_status <= ST_DONE;
            res_base   <= best_base;
            state      <= S_WRITE;
          end else begin
            res_status <= (total >= len_q) ? ST_COMPACT : ST_OOM;
            res_base   <= '0;
            state      <= S_RESP;
          end
        end
        S_WRITE: begin
          wpos <= wpos_step;
          if (wpos_step >= wend) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.granted_base  <= res_base;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_base_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_DONE || rsp.granted_base == '0))
    else $error("granted_base nonzero on a failed allocate");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> pos <= POS_W'(MEM_BYTES))
    else $error("scan position past end of map");

  a_fit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && found) |-> (best_size >= len_q && total >= best_size))
    else $error("chosen hole smaller than request");

endmodule
`default_nettype wire

FILE: sv/bha_map.sv
// Occupancy map storage: one word per row, row valid bits, registered read.
`default_nettype none
module bha_map (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bha_pkg::map_wr_t              wr,
  input  wire logic [bha_pkg::ROW_W-1:0]     rd_row,
  output logic      [bha_pkg::WORD_BITS-1:0] rd_word
);
  import bha_pkg::*;

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]      row_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    rd_data <= mem[rd_row];
    rd_ok   <= row_valid[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.row] <= 1'b1;
    end
  end

  assign rd_word = rd_ok ? rd_data : '0;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the bitmap hole allocator: directed and random requests.
module tb_top;
  import bha_pkg::*;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  localparam int PHASE_ITEMS   = 125;
  localparam int RANDOM_PHASES = 6;
  localparam int LONG_HOLD_AT  = 100;
  localparam int LONG_HOLD_LEN = 400;
  localparam int DRAIN_AT      = 300;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  typedef struct {
    int base;
    int len;
  } span_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [POS_W-1:0] cfg_data = '0;

  bitmap_hole_allocator DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the allocator
  logic [MEM_BYTES-1:0] used_map;
  logic [1:0]           fit_pol;
  logic [POS_W-1:0]     rsv_bytes;
  logic [POS_W-1:0]     scan_bytes;

  req_t  request_q[$];
  rsp_t  reply_q[$];
  span_t live_q[$];

  int issued = 0;
  int accepted = 0;
  int errors = 0;
  int n_grant = 0;
  int n_compact = 0;
  int n_oom = 0;
  int n_free = 0;
  int settings_used = 0;
  logic drain_wait = 1'b0;
  logic drained_once = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("timeout at %0t with %0d replies outstanding", $time, reply_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic rsp_t serve_request(input req_t r);
    rsp_t res;
    int   a, lim, want, total, run_base, run_len, pick_base, pick_size;
    logic found, used, take;
    res.status = ST_OOM;
    res.granted_base = '0;
    want = r.length;
    if (r.cmd == CMD_FREE) begin
      for (a = 0; a < want; a++) begin
        if (r.start_address + a >= MEM_BYTES) break;
        used_map[r.start_address + a] = 1'b0;
      end
      res.status = ST_DONE;
      return res;
    end
    if (want == 0) return res;
    lim = (scan_bytes > MEM_BYTES) ? MEM_BYTES : scan_bytes;
    total = 0;
    run_base = 0;
    run_len = 0;
    pick_base = 0;
    pick_size = 0;
    found = 1'b0;
    for (a = 0; a <= lim; a++) begin
      if (a == lim) used = 1'b1;
      else used = (a < rsv_bytes) || used_map[a];
      if (!used) begin
        if (run_len == 0) run_base = a;
        run_len++;
      end else begin
        if (run_len != 0) begin
          total += run_len;
          if (run_len >= want) begin
            take = !found;
            if (found && fit_pol == POL_BEST && run_len < pick_size) take = 1'b1;
            if (found && fit_pol == POL_WORST && run_len > pick_size) take = 1'b1;
            if (take) begin
              found = 1'b1;
              pick_base = run_base;
              pick_size = run_len;
            end
          end
        end
        run_len = 0;
      end
    end
    if (!found) begin
      res.status = (total >= want) ? ST_COMPACT : ST_OOM;
      return res;
    end
    for (a = 0; a < want; a++) begin
      if (pick_base + a < MEM_BYTES) used_map[pick_base + a] = 1'b1;
    end
    live_q.push_back('{pick_base, want});
    res.status = ST_DONE;
    res.granted_base = ADDR_W'(pick_base);
    return res;
  endfunction

  function automatic req_t make_req(input logic c, input int len, input int addr);
    req_t r;
    r.cmd = c;
    r.length = POS_W'(len);
    r.start_address = ADDR_W'(addr);
    return r;
  endfunction

  function automatic req_t next_request(input int span);
    int idx, r, odds;
    if (live_q.size() < 8) odds = 75;
    else if (live_q.size() > 40) odds = 30;
    else odds = 55;
    if ($urandom_range(0, 99) < odds) begin
      r = $urandom_range(0, 49);
      if (r == 0) return make_req(CMD_ALLOC, 0, $urandom_range(0, 4095));
      if (r < 3) return make_req(CMD_ALLOC, $urandom_range(257, span), $urandom_range(0, 4095));
      if (r < 10) return make_req(CMD_ALLOC, $urandom_range(65, 256), $urandom_range(0, 4095));
      return make_req(CMD_ALLOC, $urandom_range(1, 64), $urandom_range(0, 4095));
    end
    if (live_q.size() != 0 && $urandom_range(0, 4) != 0) begin
      idx = $urandom_range(0, live_q.size() - 1);
      r = live_q[idx].base;
      odds = live_q[idx].len;
      live_q.delete(idx);
      return make_req(CMD_FREE, odds, r);
    end
    if ($urandom_range(0, 9) == 0)
      return make_req(CMD_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
    return make_req(CMD_FREE, $urandom_range(0, 300), $urandom_range(0, 4095));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || issued != accepted || reply_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive
    int gap_left, burst_left, r;
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else if (!req_valid || req_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (request_q.size() == 0 || (drain_wait && reply_q.size() != 0)) begin
        req_valid <= 1'b0;
      end else begin
        drain_wait = 1'b0;
        req <= request_q.pop_front();
        req_valid <= 1'b1;
        issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          r = $urandom_range(0, 19);
          if (r < 10) gap_left = 0;
          else if (r < 17) gap_left = $urandom_range(1, 10);
          else gap_left = $urandom_range(11, 300);
          if ((issued >= DRAIN_AT && !drained_once) || $urandom_range(0, 39) == 0) begin
            drain_wait = 1'b1;
            drained_once = 1'b1;
            if (gap_left < 2) gap_left = 2;
          end
        end
      end
    end
  end

  // reply receiver
  always @(posedge clk) begin : receive
    int beats, hold_left, mode_left;
    logic held, rdy;
    rx_mode_t mode;
    if (rst) begin
      rsp_ready <= 1'b0;
      beats = 0;
      hold_left = 0;
      mode_left = 0;
      held = 1'b0;
      mode = RX_OPEN;
    end else begin
      if (rsp_valid && rsp_ready) beats++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (beats >= LONG_HOLD_AT && !held) begin
        held = 1'b1;
        hold_left = LONG_HOLD_LEN;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   rdy = 1'b1;
          RX_CHOPPY: rdy = 1'($urandom_range(0, 1));
          default:   rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
      rsp_ready <= rdy;
    end
  end

  // predict on request beats, check reply beats
  always @(posedge clk) begin : watch
    rsp_t want_rsp;
    if (rst) begin
      used_map = '0;
      fit_pol = POL_FIRST;
      rsv_bytes = POS_W'(128);
      scan_bytes = POS_W'(4096);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIT_POLICY:    fit_pol = cfg_data[1:0];
          REG_RESERVED_SIZE: rsv_bytes = cfg_data;
          REG_MEM_SIZE:      scan_bytes = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        want_rsp = serve_request(req);
        reply_q.push_back(want_rsp);
        accepted++;
        if (req.cmd == CMD_FREE) n_free++;
        else if (want_rsp.status == ST_DONE) n_grant++;
        else if (want_rsp.status == ST_COMPACT) n_compact++;
        else n_oom++;
      end
      if (rsp_valid && rsp_ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply status %0d base %0d", $time, rsp.status,
                   rsp.granted_base);
        end else begin
          want_rsp = reply_q.pop_front();
          if (rsp.status !== want_rsp.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want_rsp.status,
                     rsp.status);
          end
          if (rsp.granted_base !== want_rsp.granted_base) begin
            errors++;
            $display("%0t: granted_base expected %0d actual %0d", $time,
                     want_rsp.granted_base, rsp.granted_base);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int ph, k, span, waited;
    logic [1:0] pol_v;
    logic [POS_W-1:0] rsv_v, msz_v;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    request_q.push_back(make_req(CMD_ALLOC, 0, 0));
    request_q.push_back(make_req(CMD_ALLOC, 1, 4095));
    request_q.push_back(make_req(CMD_ALLOC, 4096, 0));
    request_q.push_back(make_req(CMD_ALLOC, 3967, 0));
    request_q.push_back(make_req(CMD_ALLOC, 1, 0));
    request_q.push_back(make_req(CMD_FREE, 8191, 4095));
    request_q.push_back(make_req(CMD_FREE, 4096, 0));
    request_q.push_back(make_req(CMD_FREE, 0, 4000));
    request_q.push_back(make_req(CMD_ALLOC, 100, 0));
    request_q.push_back(make_req(CMD_ALLOC, 50, 0));
    request_q.push_back(make_req(CMD_ALLOC, 200, 0));
    request_q.push_back(make_req(CMD_ALLOC, 30, 0));
    request_q.push_back(make_req(CMD_ALLOC, 300, 0));
    request_q.push_back(make_req(CMD_FREE, 50, 228));
    request_q.push_back(make_req(CMD_FREE, 30, 478));
    request_q.push_back(make_req(CMD_ALLOC, 20, 0));
    request_q.push_back(make_req(CMD_ALLOC, 3300, 0));
    wait_idle();
    write_reg(REG_FIT_POLICY, POS_W'(POL_BEST));
    request_q.push_back(make_req(CMD_ALLOC, 30, 0));
    request_q.push_back(make_req(CMD_ALLOC, 25, 0));
    wait_idle();
    write_reg(REG_FIT_POLICY, POS_W'(POL_WORST));
    request_q.push_back(make_req(CMD_ALLOC, 10, 0));
    wait_idle();
    write_reg(REG_FIT_POLICY, POS_W'(POL_UNUSED));
    request_q.push_back(make_req(CMD_ALLOC, 1, 0));
    wait_idle();
    write_reg(REG_RESERVED_SIZE, POS_W'(8191));
    request_q.push_back(make_req(CMD_ALLOC, 1, 0));
    wait_idle();
    write_reg(REG_MEM_SIZE, POS_W'(0));
    request_q.push_back(make_req(CMD_ALLOC, 1, 0));
    wait_idle();
    write_reg(REG_RESERVED_SIZE, POS_W'(0));
    write_reg(REG_MEM_SIZE, POS_W'(8191));
    request_q.push_back(make_req(CMD_FREE, 4096, 0));
    request_q.push_back(make_req(CMD_ALLOC, 4096, 0));
    request_q.push_back(make_req(CMD_FREE, 8191, 0));
    settings_used = 7;

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == 0) begin
        pol_v = POL_FIRST;
        rsv_v = POS_W'(128);
        msz_v = POS_W'(4096);
      end else if (ph == 1) begin
        pol_v = POL_BEST;
        rsv_v = POS_W'(0);
        msz_v = POS_W'(4096);
      end else if (ph == 2) begin
        pol_v = POL_WORST;
        rsv_v = POS_W'($urandom_range(1, 512));
        msz_v = POS_W'($urandom_range(1024, 4095));
      end else begin
        pol_v = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 5);
        rsv_v = (k == 0) ? POS_W'(0) : (k == 1) ? POS_W'($urandom_range(1, 1024)) : POS_W'(128);
        k = $urandom_range(0, 3);
        msz_v = (k == 0) ? POS_W'($urandom_range(1536, 4095)) :
                (k == 1) ? POS_W'($urandom_range(4097, 8191)) : POS_W'(4096);
      end
      write_reg(REG_FIT_POLICY, POS_W'(pol_v));
      write_reg(REG_RESERVED_SIZE, rsv_v);
      write_reg(REG_MEM_SIZE, msz_v);
      settings_used++;
      span = (int'(msz_v) > MEM_BYTES) ? MEM_BYTES : int'(msz_v);
      if ($urandom_range(0, 1) == 0) begin
        live_q.delete();
        request_q.push_back(make_req(CMD_FREE, 4096, 0));
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        while (request_q.size() >= 3) @(posedge clk);
        request_q.push_back(next_request(span));
      end
    end

    waited = 0;
    while ((request_q.size() != 0 || issued != accepted || reply_q.size() != 0)
           && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (reply_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected replies never arrived", $time, reply_q.size());
    end
    $display("covered %0d requests over %0d register settings", accepted, settings_used);
    $display("grants %0d, needs-compaction %0d, out-of-memory %0d, frees %0d, mismatches %0d",
             n_grant, n_compact, n_oom, n_free, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
